[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition on every clock edge outside reset
`define HFAM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after its cause
`define HFAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hfam_pkg.sv]
// ----------------------------------------------------------------------------
// hfam_pkg
// Types and helper functions of the half-float argmax stream.
// ----------------------------------------------------------------------------
package hfam_pkg;

    localparam int HALF_W  = 16;
    localparam int INDEX_W = 16;
    localparam int SINGLE_W = 32;
    localparam int KEY_W   = 17;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [HALF_W-1:0]  value;
        key_t               key;
        logic               nan;
        logic               first;
        logic               last;
        logic [INDEX_W-1:0] pos;
    } item_t;

    function automatic logic half_is_nan(input logic [HALF_W-1:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic key_t half_key(input logic [HALF_W-1:0] h);
        key_t mag;
        mag = {2'b00, h[14:0]};
        return h[15] ? -mag : mag;
    endfunction

    function automatic logic [SINGLE_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
        logic [3:0]  msb;
        logic [9:0]  norm;
        logic [7:0]  expo;
        logic [31:0] res;
        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h[i])
                msb = 4'(i);
        end
        norm = h[9:0] << (4'd10 - msb);
        expo = 8'(msb) + 8'd103;
        if (h[14:10] == 5'h1F)
        begin
            if (h[9:0] == 10'd0)
                res = {h[15], 8'hFF, 23'd0};
            else
                res = {h[15], 8'hFF, 1'b1, h[8:0], 13'd0};
        end
        else if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
                res = {h[15], 31'd0};
            else
                res = {h[15], expo, norm, 13'd0};
        end
        else
        begin
            res = {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
        end
        return res;
    endfunction

endpackage

[rtl/core/hfam_if.sv]
// ----------------------------------------------------------------------------
// hfam_if
// Stream interfaces for input elements and argmax results.
// ----------------------------------------------------------------------------
interface hfam_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_value;
    logic        last;
    modport source (output valid, output half_value, output last, input ready);
    modport sink   (input valid, input half_value, input last, output ready);
endinterface

interface hfam_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] best_index;
    logic [31:0] best_value_bits;
    modport source (output valid, output best_index, output best_value_bits, input ready);
    modport sink   (input valid, input best_index, input best_value_bits, output ready);
endinterface

[rtl/core/hfam_front.sv]
// ----------------------------------------------------------------------------
// hfam_front
// Accepts elements, assigns positions and classifies each value.
// ----------------------------------------------------------------------------
module hfam_front
    import hfam_pkg::*;
#(
    parameter logic [INDEX_W-1:0] CAP = 16'hFFFF
)
(
    input  logic         clk,
    input  logic         rst_n,
    hfam_in_if.sink      in_stream,
    input  logic         q_full,
    output logic         push,
    output item_t        push_item
);

    logic [INDEX_W-1:0] count_reg, count_next;
    logic               started_reg, started_next;

    assign in_stream.ready = !q_full;
    assign push            = in_stream.valid && !q_full;

    always_comb
    begin
        push_item.value = in_stream.half_value;
        push_item.key   = half_key(in_stream.half_value);
        push_item.nan   = half_is_nan(in_stream.half_value);
        push_item.first = !started_reg;
        push_item.last  = in_stream.last;
        push_item.pos   = started_reg ? count_reg : '0;
    end

    always_comb
    begin
        count_next   = count_reg;
        started_next = started_reg;
        if (push)
        begin
            if (in_stream.last)
            begin
                count_next   = '0;
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                if (push_item.pos < CAP)
                    count_next = push_item.pos + 1'b1;
                else
                    count_next = push_item.pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            started_reg <= started_next;
        end
    end

endmodule

[rtl/core/hfam_queue.sv]
// ----------------------------------------------------------------------------
// hfam_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module hfam_queue
    import hfam_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output item_t q_item
);

    item_t      mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg, fill_next;

    assign full    = fill_reg[1];
    assign q_valid = fill_reg != 2'd0;
    assign q_item  = mem_reg[rd_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/core/hfam_back.sv]
// ----------------------------------------------------------------------------
// hfam_back
// Keeps the running maximum and emits the widened result per vector.
// ----------------------------------------------------------------------------
module hfam_back
    import hfam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  item_t     q_item,
    output logic      pop,
    hfam_out_if.source out_stream
);

    logic [HALF_W-1:0]  best_half_reg;
    key_t               best_key_reg;
    logic               best_nan_reg;
    logic [INDEX_W-1:0] best_pos_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [SINGLE_W-1:0] out_bits_reg;

    logic               take;
    logic [HALF_W-1:0]  sel_half;
    logic [INDEX_W-1:0] sel_pos;

    assign pop  = q_valid && (!q_item.last || !out_valid_reg || out_stream.ready);
    assign take = q_item.first ||
                  (!q_item.nan && !best_nan_reg && (q_item.key > best_key_reg));
    assign sel_half = take ? q_item.value : best_half_reg;
    assign sel_pos  = take ? q_item.pos : best_pos_reg;

    assign out_stream.valid           = out_valid_reg;
    assign out_stream.best_index      = out_index_reg;
    assign out_stream.best_value_bits = out_bits_reg;

    always_ff @(posedge clk)
    begin
        if (pop && take)
        begin
            best_half_reg <= q_item.value;
            best_key_reg  <= q_item.key;
            best_nan_reg  <= q_item.nan;
            best_pos_reg  <= q_item.pos;
        end
        if (pop && q_item.last)
        begin
            out_index_reg <= sel_pos;
            out_bits_reg  <= half_to_single(sel_half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && q_item.last)
            out_valid_reg <= 1'b1;
        else if (out_stream.ready)
            out_valid_reg <= 1'b0;
    end

endmodule

[rtl/core/half_float_argmax_stream_top.sv]
// ----------------------------------------------------------------------------
// half_float_argmax_stream_top
// First-maximum search over binary16 vectors with binary32 result.
// ----------------------------------------------------------------------------
//   channel     dir  payload                        per
//   in_stream   in   half_value[15:0], last         element
//   out_stream  out  best_index[15:0], best_value   vector (on last)
//
// One element per cycle while the queue has room, set by the single
// compare-and-select in the back part. A result is registered as its last
// element leaves the queue; a last element waits while a result is unaccepted.
// Reset clears positions, queue and output valid; no clearing pass.
// The two-entry queue lets input flow while a result waits on out_stream.ready.
module half_float_argmax_stream_top
    import hfam_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    hfam_in_if.sink    in_stream,
    hfam_out_if.source out_stream
);

    localparam logic [INDEX_W-1:0] CAP =
        (MAX_ITEMS - 1 > 65535) ? 16'hFFFF : INDEX_W'(MAX_ITEMS - 1);

    logic  push, pop, q_full, q_valid;
    item_t push_item, q_item;

    hfam_front #(.CAP(CAP)) u_front (
        .clk(clk), .rst_n(rst_n), .in_stream(in_stream),
        .q_full(q_full), .push(push), .push_item(push_item)
    );

    hfam_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
        .full(q_full), .pop(pop), .q_valid(q_valid), .q_item(q_item)
    );

    hfam_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .pop(pop), .out_stream(out_stream)
    );

endmodule

[rtl/core/hfam_checker.sv]
// ----------------------------------------------------------------------------
// hfam_checker
// Port-level checks of the argmax result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfam_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] best_index,
    input logic [31:0] best_value_bits
);

    `HFAM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(best_index) && $stable(best_value_bits), "stalled result changed")
    `HFAM_ASSERT(a_exact, !out_valid || (best_value_bits[12:0] == 13'd0), "widening not exact")
    `HFAM_ASSERT(a_quiet, !out_valid || (best_value_bits[30:23] != 8'hFF) || (best_value_bits[22:0] == 23'd0) || best_value_bits[22], "signaling NaN emitted")
    `HFAM_ASSERT(a_norm, !out_valid || (best_value_bits[30:23] != 8'd0) || (best_value_bits[22:0] == 23'd0), "subnormal emitted")

endmodule

bind half_float_argmax_stream_top hfam_checker u_hfam_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_stream.valid), .out_ready(out_stream.ready),
    .best_index(out_stream.best_index), .best_value_bits(out_stream.best_value_bits)
);

[tb/half_float_argmax_stream_checker.sv]
// ----------------------------------------------------------------------------
// half_float_argmax_stream_checker
// Watches the element and result channels, tracks the running first maximum
// of each vector and compares every result with the expected index and the
// widened binary32 value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module half_float_argmax_stream_checker
    import hfam_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    hfam_in_if.sink    in_mon,
    hfam_out_if.sink   out_mon,
    output int         error_count,
    output int         pending_count
);

    typedef struct {
        logic [15:0] index;
        logic [31:0] value_bits;
    } argmax_result_t;

    argmax_result_t expected_results[$];
    logic [15:0] best_half;
    logic [15:0] best_position;
    logic [15:0] position_count;
    logic        vector_started;

    function automatic logic is_nan16(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 0);
    endfunction

    function automatic int order_key16(input logic [15:0] h);
        return h[15] ? -int'(h[14:0]) : int'(h[14:0]);
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sign;
        logic [9:0]  mant;
        int          expo;
        sign = {h[15], 31'd0};
        mant = h[9:0];
        if (h[14:10] == 5'h1F)
            return (mant == 0) ? (sign | 32'h7F80_0000)
                               : (sign | 32'h7FC0_0000 | (32'(mant) << 13));
        if (h[14:10] == 0)
        begin
            if (mant == 0)
                return sign;
            expo = -14;
            while (!mant[9])
            begin
                mant = mant << 1;
                expo--;
            end
            mant = mant << 1;
            expo--;
            return sign | (32'(expo + 127) << 23) | (32'(mant) << 13);
        end
        return sign | (32'(h[14:10] + 112) << 23) | (32'(mant) << 13);
    endfunction

    function automatic logic [15:0] position_cap();
        return (MAX_ITEMS - 1 > 65535) ? 16'hFFFF : 16'(MAX_ITEMS - 1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        argmax_result_t got;
        argmax_result_t want;
        logic [15:0]    v;
        int             errs;
        errs = 0;
        if (!rst_n)
        begin
            best_half      = '0;
            best_position  = '0;
            position_count = '0;
            vector_started = 1'b0;
            error_count    <= 0;
            expected_results.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got.index      = out_mon.best_index;
                got.value_bits = out_mon.best_value_bits;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result index=%0d value=%h", got.index,
                           got.value_bits);
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.index !== want.index)
                    begin
                        $error("best_index expected %0d actual %0d", want.index, got.index);
                        errs = errs + 1;
                    end
                    if (got.value_bits !== want.value_bits)
                    begin
                        $error("best_value_bits expected %h actual %h", want.value_bits,
                               got.value_bits);
                        errs = errs + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                v = in_mon.half_value;
                if (!vector_started)
                begin
                    best_half      = v;
                    best_position  = 0;
                    position_count = 0;
                end
                else if (!is_nan16(v) && !is_nan16(best_half)
                         && order_key16(v) > order_key16(best_half))
                begin
                    best_half     = v;
                    best_position = position_count;
                end
                if (in_mon.last)
                begin
                    want.index      = best_position;
                    want.value_bits = widen_half(best_half);
                    expected_results.push_back(want);
                    vector_started = 1'b0;
                    position_count = '0;
                end
                else
                begin
                    vector_started = 1'b1;
                    if (position_count < position_cap())
                        position_count = position_count + 1'b1;
                end
            end
            error_count <= error_count + errs;
        end
        pending_count <= expected_results.size();
    end

endmodule

[tb/half_float_argmax_stream_top_tb.sv]
// ----------------------------------------------------------------------------
// half_float_argmax_stream_top_tb
// Drives binary16 vectors (directed edge values, then random vectors with
// varied lengths and sender/receiver stalls) and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module half_float_argmax_stream_top_tb;

    localparam int MAX_ITEMS = 65536;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pending_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    hfam_in_if  in_stream();
    hfam_out_if out_stream();

    half_float_argmax_stream_top #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .out_stream (out_stream)
    );

    half_float_argmax_stream_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_stream),
        .out_mon       (out_stream),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        out_stream.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_element(input logic [15:0] h, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_stream.valid <= 1'b0;
            @(posedge clk);
        end
        in_stream.valid      <= 1'b1;
        in_stream.half_value <= h;
        in_stream.last       <= is_last;
        @(posedge clk);
        while (!in_stream.ready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] random_half();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023))};
            1: return {1'($urandom_range(1)), 5'h00, 10'($urandom_range(1023))};
            2: return {1'($urandom_range(1)), 15'h0000};
            3: return {1'($urandom_range(1)), 5'h1F, 10'd0};
            4: return 16'h3C00 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_element(random_half(), i == len - 1);
    endtask

    task automatic run_phase(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            send_vector(len);
            sent += len;
        end
    endtask

    initial
    begin
        cycle_count          = 0;
        send_idle_pct        = 0;
        recv_idle_pct        = 0;
        in_stream.valid      = 1'b0;
        in_stream.half_value = '0;
        in_stream.last       = 1'b0;
        out_stream.ready     = 1'b0;
        rst_n                = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_element(16'h7E01, 1'b0);
        send_element(16'h7C00, 1'b0);
        send_element(16'h3C00, 1'b1);
        send_element(16'h5555, 1'b1);
        send_element(16'h8000, 1'b0);
        send_element(16'h0000, 1'b1);
        send_element(16'hFC00, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'h0200, 1'b0);
        send_element(16'h0001, 1'b1);
        send_element(16'hFFFF, 1'b0);
        send_element(16'h7C00, 1'b1);
        send_element(16'h3C00, 1'b0);
        send_element(16'hFE00, 1'b0);
        send_element(16'h7BFF, 1'b0);
        send_element(16'h7C00, 1'b0);
        send_element(16'h7FFF, 1'b1);
        send_element(16'hAAAA, 1'b0);
        send_element(16'h83FF, 1'b1);

        send_idle_pct = 17;
        recv_idle_pct = 84;
        run_phase(200);
        send_idle_pct = 84;
        recv_idle_pct = 17;
        run_phase(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(200);

        in_stream.valid <= 1'b0;
        recv_idle_pct = 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[half_float_argmax_stream_top.f]
+incdir+rtl/core
rtl/core/hfam_pkg.sv
rtl/core/hfam_if.sv
rtl/core/hfam_front.sv
rtl/core/hfam_queue.sv
rtl/core/hfam_back.sv
rtl/core/half_float_argmax_stream_top.sv
rtl/core/hfam_checker.sv
tb/half_float_argmax_stream_checker.sv
tb/half_float_argmax_stream_top_tb.sv
